// File: rtl/msbi_pkg.sv
// shared types, constants and bit-interleave helpers for the morton box index
`default_nettype none
package msbi_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int MATCH_CAP = 64;
	localparam int NW = $clog2(MATCH_CAP + 1);

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_BUILD = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_UNBUILT = 2'd2;

	typedef struct packed {
		logic [63:0] id;
		logic [63:0] code;
	} entry_t;

	// put v on the even bits of a 64-bit word
	function automatic logic [63:0] spread32(input logic [31:0] v);
		logic [63:0] x;
		x = '0;
		for (int b = 0; b < 32; b++) begin
			x[2*b] = v[b];
		end
		return x;
	endfunction

	// collect the even bits of a 64-bit word
	function automatic logic [31:0] gather32(input logic [63:0] v);
		logic [31:0] x;
		x = '0;
		for (int b = 0; b < 32; b++) begin
			x[b] = v[2*b];
		end
		return x;
	endfunction

	function automatic logic [63:0] morton(input logic [31:0] lat, input logic [31:0] lng);
		return spread32(lat) | (spread32(lng) << 1);
	endfunction

endpackage
`default_nettype wire

// File: rtl/morton_sorted_bbox_index.sv
// top level of the morton-coded spatial index with sorted box queries
`default_nettype none
// Z-order spatial index over one 1024-entry table held in a single-port-write,
// registered-read memory of {id, code} words. A command is taken when start is
// high and busy is low; every result appears for one cycle with done high and
// cannot be held off, and last marks the final result of a command. Add, clear,
// a build of an already built table or of fewer than two entries, and a query
// on an unbuilt table answer in the cycle after the transfer. A build runs an
// in-memory insertion sort: for each key it reads and captures the key, then
// reads the left neighbor and compares and shifts until the key lands. A query
// runs a lower-bound binary search (probe, then narrow, per step), then scans
// entries (read, then test) until the code passes the upper corner, the match
// cap is hit or the table ends, then emits the final result. Matches stream
// out as found, one result held back so the last can carry last and truncated.
module morton_sorted_bbox_index
	import msbi_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [63:0] record_id,
	input  wire logic [31:0] point_lat,
	input  wire logic [31:0] point_lng,
	input  wire logic [31:0] box_min_lat,
	input  wire logic [31:0] box_max_lat,
	input  wire logic [31:0] box_min_lng,
	input  wire logic [31:0] box_max_lng,
	output logic             done,
	output logic [1:0]       status,
	output logic             found,
	output logic [63:0]      match_id,
	output logic [63:0]      match_code,
	output logic             truncated,
	output logic             last
);

	// sequencer codes
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SK   = 4'd1;  // sort: read key
	localparam logic [3:0] S_SKW  = 4'd2;  // sort: capture key
	localparam logic [3:0] S_SR   = 4'd3;  // sort: read left neighbor
	localparam logic [3:0] S_SC   = 4'd4;  // sort: compare and shift
	localparam logic [3:0] S_BS   = 4'd5;  // search: probe
	localparam logic [3:0] S_BW   = 4'd6;  // search: narrow
	localparam logic [3:0] S_QR   = 4'd7;  // scan: read
	localparam logic [3:0] S_QW   = 4'd8;  // scan: test
	localparam logic [3:0] S_FIN  = 4'd9;  // final result

	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q, i_q, j_q, lo_q, hi_q;
	logic [AW-1:0] mid_q;
	logic          built_q;
	entry_t        key_q, held_q, rd_q;
	logic          held_v_q, over_q;
	logic [NW-1:0] n_q;
	logic [63:0]   zlo_q, zhi_q;
	logic [31:0]   mnla_q, mxla_q, mnlg_q, mxlg_q;

	entry_t mem [TABLE_DEPTH];

	logic          we;
	logic [AW-1:0] wa, ra;
	entry_t        wd;
	logic          accept;
	logic [CW-1:0] mid_c;
	logic [63:0]   za_c, zb_c;
	logic [31:0]   la_c, lg_c;
	logic          inside_c;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign mid_c  = lo_q + ((hi_q - lo_q) >> 1);
	assign za_c   = morton(box_min_lat, box_min_lng);
	assign zb_c   = morton(box_max_lat, box_max_lng);
	assign la_c   = gather32(rd_q.code);
	assign lg_c   = gather32({1'b0, rd_q.code[63:1]});
	assign inside_c = (la_c >= mnla_q) && (la_c <= mxla_q)
		&& (lg_c >= mnlg_q) && (lg_c <= mxlg_q);

	// memory port control
	always_comb begin
		we = 1'b0;
		wa = cnt_q[AW-1:0];
		wd = '{id: record_id, code: morton(point_lat, point_lng)};
		ra = i_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				we = accept && (command == CMD_ADD) && (cnt_q < CW'(TABLE_DEPTH));
			end
			S_SR: begin
				ra = AW'(j_q - CW'(1));
				if (j_q == '0) begin
					we = 1'b1;
					wa = '0;
					wd = key_q;
				end
			end
			S_SC: begin
				we = 1'b1;
				wa = j_q[AW-1:0];
				wd = (rd_q.code > key_q.code) ? rd_q : key_q;
			end
			S_BS: ra = mid_c[AW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			built_q    <= 1'b0;
			done       <= 1'b0;
			status     <= ST_OK;
			found      <= 1'b0;
			match_id   <= '0;
			match_code <= '0;
			truncated  <= 1'b0;
			last       <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			lo_q       <= '0;
			hi_q       <= '0;
			mid_q      <= '0;
			n_q        <= '0;
			over_q     <= 1'b0;
			held_v_q   <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						// default reply: one plain ok result
						status     <= ST_OK;
						found      <= 1'b0;
						match_id   <= '0;
						match_code <= '0;
						truncated  <= 1'b0;
						last       <= 1'b1;
						done       <= 1'b1;
						unique case (command)
							CMD_ADD: begin
								if (cnt_q < CW'(TABLE_DEPTH)) begin
									cnt_q   <= cnt_q + CW'(1);
									built_q <= 1'b0;
								end else begin
									status <= ST_FULL;
								end
							end
							CMD_BUILD: begin
								if (!built_q && cnt_q > CW'(1)) begin
									done    <= 1'b0;
									i_q     <= CW'(1);
									state_q <= S_SK;
								end else begin
									built_q <= 1'b1;
								end
							end
							CMD_CLEAR: begin
								cnt_q   <= '0;
								built_q <= 1'b0;
							end
							CMD_QUERY: begin
								if (!built_q) begin
									status <= ST_UNBUILT;
								end else begin
									done     <= 1'b0;
									zlo_q    <= (za_c > zb_c) ? zb_c : za_c;
									zhi_q    <= (za_c > zb_c) ? za_c : zb_c;
									mnla_q   <= box_min_lat;
									mxla_q   <= box_max_lat;
									mnlg_q   <= box_min_lng;
									mxlg_q   <= box_max_lng;
									lo_q     <= '0;
									hi_q     <= cnt_q;
									n_q      <= '0;
									over_q   <= 1'b0;
									held_v_q <= 1'b0;
									state_q  <= S_BS;
								end
							end
							default: ;
						endcase
					end
				end
				S_SK:  state_q <= S_SKW;
				S_SKW: begin
					key_q   <= rd_q;
					j_q     <= i_q;
					state_q <= S_SR;
				end
				S_SR: begin
					if (j_q == '0) begin
						// key lands at the head; move to next key
						if (i_q + CW'(1) >= cnt_q) begin
							built_q    <= 1'b1;
							status     <= ST_OK;
							found      <= 1'b0;
							match_id   <= '0;
							match_code <= '0;
							truncated  <= 1'b0;
							last       <= 1'b1;
							done       <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							state_q <= S_SK;
						end
						i_q <= i_q + CW'(1);
					end else begin
						state_q <= S_SC;
					end
				end
				S_SC: begin
					if (rd_q.code > key_q.code) begin
						j_q     <= j_q - CW'(1);
						state_q <= S_SR;
					end else begin
						if (i_q + CW'(1) >= cnt_q) begin
							built_q    <= 1'b1;
							status     <= ST_OK;
							found      <= 1'b0;
							match_id   <= '0;
							match_code <= '0;
							truncated  <= 1'b0;
							last       <= 1'b1;
							done       <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							state_q <= S_SK;
						end
						i_q <= i_q + CW'(1);
					end
				end
				S_BS: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid_c[AW-1:0];
						state_q <= S_BW;
					end else begin
						i_q     <= lo_q;
						state_q <= S_QR;
					end
				end
				S_BW: begin
					if (rd_q.code < zlo_q) begin
						lo_q <= {1'b0, mid_q} + CW'(1);
					end else begin
						hi_q <= {1'b0, mid_q};
					end
					state_q <= S_BS;
				end
				S_QR: begin
					state_q <= (i_q < cnt_q) ? S_QW : S_FIN;
				end
				S_QW: begin
					if (rd_q.code > zhi_q) begin
						state_q <= S_FIN;
					end else if (inside_c && n_q == NW'(MATCH_CAP)) begin
						over_q  <= 1'b1;
						state_q <= S_FIN;
					end else begin
						if (inside_c) begin
							// release the held match, keep this one back
							if (held_v_q) begin
								status     <= ST_OK;
								found      <= 1'b1;
								match_id   <= held_q.id;
								match_code <= held_q.code;
								truncated  <= 1'b0;
								last       <= 1'b0;
								done       <= 1'b1;
							end
							held_q   <= rd_q;
							held_v_q <= 1'b1;
							n_q      <= n_q + NW'(1);
						end
						i_q     <= i_q + CW'(1);
						state_q <= S_QR;
					end
				end
				S_FIN: begin
					status     <= ST_OK;
					found      <= held_v_q;
					match_id   <= held_v_q ? held_q.id : '0;
					match_code <= held_v_q ? held_q.code : '0;
					truncated  <= held_v_q && over_q;
					last       <= 1'b1;
					done       <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks on the sequencer
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH)) else $error("entry count past depth");
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && truncated |-> last && found) else $error("truncated off final match");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == ST_OK) else $error("match with bad status");
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= NW'(MATCH_CAP)) else $error("match count past cap");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && last |-> state_q == S_IDLE) else $error("final result while busy");

endmodule
`default_nettype wire

// File: tb/morton_sorted_bbox_index_tb.sv
// testbench for the morton box index: directed and random command streams, checked per result
`timescale 1ns / 100ps
module morton_sorted_bbox_index_tb;
	import msbi_pkg::*;

	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct {
		logic [1:0]  cmd;
		logic [63:0] id;
		logic [31:0] plat;
		logic [31:0] plng;
		logic [31:0] mnla;
		logic [31:0] mxla;
		logic [31:0] mnlg;
		logic [31:0] mxlg;
	} cmd_item_t;

	typedef struct {
		logic [1:0]  status;
		logic        found;
		logic [63:0] id;
		logic [63:0] code;
		logic        truncated;
		logic        last;
	} index_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [63:0] record_id;
	logic [31:0] point_lat;
	logic [31:0] point_lng;
	logic [31:0] box_min_lat;
	logic [31:0] box_max_lat;
	logic [31:0] box_min_lng;
	logic [31:0] box_max_lng;
	logic        done;
	logic [1:0]  status;
	logic        found;
	logic [63:0] match_id;
	logic [63:0] match_code;
	logic        truncated;
	logic        last;

	// shadow copy of the index
	logic [63:0] shadow_id[TABLE_DEPTH];
	logic [63:0] shadow_code[TABLE_DEPTH];
	int          shadow_count;
	bit          shadow_built;

	index_result_t pending_results[$];
	int errors;
	int n_items;
	int n_queries;
	int n_matches;
	int n_truncated;
	int idle_cycles;

	morton_sorted_bbox_index u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.record_id   (record_id),
		.point_lat   (point_lat),
		.point_lng   (point_lng),
		.box_min_lat (box_min_lat),
		.box_max_lat (box_max_lat),
		.box_min_lng (box_min_lng),
		.box_max_lng (box_max_lng),
		.done        (done),
		.status      (status),
		.found       (found),
		.match_id    (match_id),
		.match_code  (match_code),
		.truncated   (truncated),
		.last        (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// interleave lat onto even bits, lng onto odd bits
	function automatic logic [63:0] z_encode(logic [31:0] lat, logic [31:0] lng);
		logic [63:0] a;
		logic [63:0] b;
		a = {32'd0, lat};
		b = {32'd0, lng};
		a = (a | (a << 16)) & 64'h0000FFFF0000FFFF;
		a = (a | (a << 8))  & 64'h00FF00FF00FF00FF;
		a = (a | (a << 4))  & 64'h0F0F0F0F0F0F0F0F;
		a = (a | (a << 2))  & 64'h3333333333333333;
		a = (a | (a << 1))  & 64'h5555555555555555;
		b = (b | (b << 16)) & 64'h0000FFFF0000FFFF;
		b = (b | (b << 8))  & 64'h00FF00FF00FF00FF;
		b = (b | (b << 4))  & 64'h0F0F0F0F0F0F0F0F;
		b = (b | (b << 2))  & 64'h3333333333333333;
		b = (b | (b << 1))  & 64'h5555555555555555;
		return a | (b << 1);
	endfunction

	function automatic logic [31:0] z_even_bits(logic [63:0] v);
		logic [31:0] r;
		r = '0;
		for (int k = 0; k < 32; k++) begin
			r[k] = v[2*k];
		end
		return r;
	endfunction

	function automatic index_result_t plain_result(logic [1:0] st);
		index_result_t r;
		r.status = st;
		r.found = 1'b0;
		r.id = '0;
		r.code = '0;
		r.truncated = 1'b0;
		r.last = 1'b1;
		return r;
	endfunction

	// work out the results of one accepted command and update the shadow index
	task automatic predict_index(input cmd_item_t it);
		logic [63:0] zlo;
		logic [63:0] zhi;
		logic [63:0] tmp;
		logic [63:0] c;
		logic [63:0] d;
		logic [31:0] la;
		logic [31:0] lg;
		index_result_t r;
		int j;
		int n;
		case (it.cmd)
			CMD_ADD: begin
				if (shadow_count >= TABLE_DEPTH) begin
					pending_results.push_back(plain_result(ST_FULL));
				end else begin
					shadow_id[shadow_count] = it.id;
					shadow_code[shadow_count] = z_encode(it.plat, it.plng);
					shadow_count++;
					shadow_built = 1'b0;
					pending_results.push_back(plain_result(ST_OK));
				end
			end
			CMD_BUILD: begin
				if (!shadow_built) begin
					// stable insertion sort, ties keep insertion order
					for (int i = 1; i < shadow_count; i++) begin
						c = shadow_code[i];
						d = shadow_id[i];
						j = i;
						while (j > 0 && shadow_code[j-1] > c) begin
							shadow_code[j] = shadow_code[j-1];
							shadow_id[j] = shadow_id[j-1];
							j--;
						end
						shadow_code[j] = c;
						shadow_id[j] = d;
					end
					shadow_built = 1'b1;
				end
				pending_results.push_back(plain_result(ST_OK));
			end
			CMD_CLEAR: begin
				shadow_count = 0;
				shadow_built = 1'b0;
				pending_results.push_back(plain_result(ST_OK));
			end
			default: begin
				n_queries++;
				if (!shadow_built) begin
					pending_results.push_back(plain_result(ST_UNBUILT));
				end else begin
					zlo = z_encode(it.mnla, it.mnlg);
					zhi = z_encode(it.mxla, it.mxlg);
					if (zlo > zhi) begin
						tmp = zlo;
						zlo = zhi;
						zhi = tmp;
					end
					n = 0;
					// sorted table: a forward walk over the code window matches the search order
					for (int i = 0; i < shadow_count; i++) begin
						c = shadow_code[i];
						if (c > zhi) break;
						if (c >= zlo) begin
							la = z_even_bits(c);
							lg = z_even_bits(c >> 1);
							if (la >= it.mnla && la <= it.mxla && lg >= it.mnlg && lg <= it.mxlg) begin
								if (n >= MATCH_CAP) begin
									pending_results[$].truncated = 1'b1;
									n_truncated++;
									break;
								end
								r.status = ST_OK;
								r.found = 1'b1;
								r.id = shadow_id[i];
								r.code = c;
								r.truncated = 1'b0;
								r.last = 1'b0;
								pending_results.push_back(r);
								n++;
								n_matches++;
							end
						end
					end
					if (n == 0) begin
						pending_results.push_back(plain_result(ST_OK));
					end else begin
						pending_results[$].last = 1'b1;
					end
				end
			end
		endcase
	endtask

	// one command transfer; start stays high when the next gap is zero
	task automatic send_command(input cmd_item_t it, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		command     <= it.cmd;
		record_id   <= it.id;
		point_lat   <= it.plat;
		point_lng   <= it.plng;
		box_min_lat <= it.mnla;
		box_max_lat <= it.mxla;
		box_min_lng <= it.mnlg;
		box_max_lng <= it.mxlg;
		start       <= 1'b1;
		do @(posedge clk); while (busy);
		predict_index(it);
		n_items++;
	endtask

	function automatic cmd_item_t random_fields(logic [1:0] cmd);
		cmd_item_t it;
		it.cmd = cmd;
		it.id = {$urandom, $urandom};
		it.plat = $urandom;
		it.plng = $urandom;
		it.mnla = $urandom;
		it.mxla = $urandom;
		it.mnlg = $urandom;
		it.mxlg = $urandom;
		return it;
	endfunction

	function automatic cmd_item_t add_item(logic [63:0] id, logic [31:0] lat, logic [31:0] lng);
		cmd_item_t it;
		it = random_fields(CMD_ADD);
		it.id = id;
		it.plat = lat;
		it.plng = lng;
		return it;
	endfunction

	function automatic cmd_item_t box_item(logic [31:0] mnla, logic [31:0] mxla,
	                                       logic [31:0] mnlg, logic [31:0] mxlg);
		cmd_item_t it;
		it = random_fields(CMD_QUERY);
		it.mnla = mnla;
		it.mxla = mxla;
		it.mnlg = mnlg;
		it.mxlg = mxlg;
		return it;
	endfunction

	function automatic int rand_gap();
		// about three in seven commands go back to back
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 6);
	endfunction

	// sender pauses until every expected result is in, then lets the block settle
	task automatic drain_results();
		start <= 1'b0;
		while (pending_results.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic test_basic_commands();
		send_command(box_item(0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF), rand_gap());
		send_command(add_item(64'd0, 32'd0, 32'd0), rand_gap());
		send_command(add_item(64'hFFFFFFFFFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF), rand_gap());
		send_command(add_item(64'h0123456789ABCDEF, 32'hFFFFFFFF, 32'd0), rand_gap());
		send_command(add_item(64'hFEDCBA9876543210, 32'd0, 32'hFFFFFFFF), rand_gap());
		send_command(add_item(64'd5, 32'd2, 32'd1), rand_gap());
		send_command(box_item(0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF), rand_gap());
		send_command(random_fields(CMD_BUILD), rand_gap());
		send_command(random_fields(CMD_BUILD), rand_gap());
		send_command(box_item(0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF), rand_gap());
		// inverted box
		send_command(box_item(32'd9, 32'd1, 32'd0, 32'hFFFFFFFF), rand_gap());
		// empty region
		send_command(box_item(32'd100, 32'd200, 32'd100, 32'd200), rand_gap());
		// corner codes out of order
		send_command(box_item(32'd2, 32'd0, 32'd0, 32'd1), rand_gap());
		send_command(box_item(32'd1, 32'd3, 32'd0, 32'd2), rand_gap());
		send_command(random_fields(CMD_CLEAR), rand_gap());
		send_command(random_fields(CMD_BUILD), rand_gap());
		send_command(box_item(0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF), rand_gap());
		drain_results();
	endtask

	task automatic test_tie_order();
		send_command(random_fields(CMD_CLEAR), rand_gap());
		for (int i = 0; i < 6; i++) begin
			send_command(add_item(64'd100 + i, 32'd7 - (i % 2), 32'd3), rand_gap());
		end
		send_command(random_fields(CMD_BUILD), rand_gap());
		send_command(box_item(32'd6, 32'd7, 32'd3, 32'd3), rand_gap());
		drain_results();
	endtask

	task automatic test_match_cap();
		send_command(random_fields(CMD_CLEAR), 0);
		for (int i = 0; i < MATCH_CAP + 6; i++) begin
			send_command(add_item({$urandom, $urandom}, 32'd40 + (i % 3), 32'd50), 0);
		end
		send_command(random_fields(CMD_BUILD), rand_gap());
		send_command(box_item(32'd40, 32'd42, 32'd50, 32'd50), rand_gap());
		drain_results();
	endtask

	task automatic test_random_sequences();
		cmd_item_t it;
		logic [31:0] base_lat;
		logic [31:0] base_lng;
		int spread;
		int n_add;
		int sent;
		sent = 0;
		while (sent < 30) begin
			base_lat = ($urandom_range(0, 3) == 0) ? 32'hFFFFFF00 : $urandom;
			base_lng = ($urandom_range(0, 3) == 0) ? 32'h00000000 : $urandom;
			if (base_lat > 32'hFFFFFF00) base_lat = 32'hFFFFFF00;
			if (base_lng > 32'hFFFFFF00) base_lng = 32'hFFFFFF00;
			spread = $urandom_range(3, 60);
			n_add = $urandom_range(1, 24);
			if ($urandom_range(0, 1) == 0) begin
				send_command(random_fields(CMD_CLEAR), rand_gap());
				sent++;
			end
			for (int i = 0; i < n_add; i++) begin
				if ($urandom_range(0, 9) == 0) it = random_fields(CMD_ADD);
				else it = add_item({$urandom, $urandom}, base_lat + $urandom_range(0, spread),
				                   base_lng + $urandom_range(0, spread));
				send_command(it, rand_gap());
				sent++;
			end
			// sometimes query before building
			if ($urandom_range(0, 4) == 0) begin
				send_command(random_fields(CMD_QUERY), rand_gap());
				sent++;
			end
			send_command(random_fields(CMD_BUILD), rand_gap());
			sent++;
			for (int q = 0; q < 3; q++) begin
				case ($urandom_range(0, 5))
					0: it = random_fields(CMD_QUERY);
					1: it = box_item(base_lat + $urandom_range(0, spread), base_lat,
					                 base_lng, base_lng + $urandom_range(0, spread));
					2: it = box_item(0, 32'hFFFFFFFF, 0, 32'hFFFFFFFF);
					default: it = box_item(base_lat + $urandom_range(0, spread / 2),
					                       base_lat + $urandom_range(spread / 2, spread),
					                       base_lng + $urandom_range(0, spread / 2),
					                       base_lng + $urandom_range(spread / 2, spread));
				endcase
				send_command(it, rand_gap());
				sent++;
			end
		end
		drain_results();
	endtask

	// compare every result against the oldest expectation
	always @(posedge clk) begin
		index_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d found=%0d id=%h", $time,
				         status, found, match_id);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $time, e.status, status);
					errors++;
				end
				if (found !== e.found) begin
					$display("%0t: found expected %0d actual %0d", $time, e.found, found);
					errors++;
				end
				if (match_id !== e.id) begin
					$display("%0t: match_id expected %h actual %h", $time, e.id, match_id);
					errors++;
				end
				if (match_code !== e.code) begin
					$display("%0t: match_code expected %h actual %h", $time, e.code, match_code);
					errors++;
				end
				if (truncated !== e.truncated) begin
					$display("%0t: truncated expected %0d actual %0d", $time, e.truncated,
					         truncated);
					errors++;
				end
				if (last !== e.last) begin
					$display("%0t: last expected %0d actual %0d", $time, e.last, last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transfer in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results outstanding", $time,
			         pending_results.size());
			$display("status: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		errors = 0;
		n_items = 0;
		n_queries = 0;
		n_matches = 0;
		n_truncated = 0;
		idle_cycles = 0;
		shadow_count = 0;
		shadow_built = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_ADD;
		record_id = '0;
		point_lat = '0;
		point_lng = '0;
		box_min_lat = '0;
		box_max_lat = '0;
		box_min_lng = '0;
		box_max_lng = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_commands();
		test_tie_order();
		test_match_cap();
		test_random_sequences();
		if (pending_results.size() > 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending_results.size());
			errors++;
		end
		$display("covered %0d commands, %0d box queries, %0d matches, %0d capped queries",
		         n_items, n_queries, n_matches, n_truncated);
		$display("including the match cap, tie ordering and unbuilt, inverted and empty boxes");
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
